/* rtl/assert_macros.svh */
// Assertion macros used by the checker okvt_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("checker assertion failed");

// Condition never holds at a clock edge outside reset.
`define CHK_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("checker forbidden condition seen");

`endif

/* rtl/okvt_pkg.sv */
package okvt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_LOOKUP = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       clear;
      logic       append;
      logic       scan_start;
      logic       scan_next;
      logic       shift;
      logic       dec;
      logic       respond;
      logic       take_value;
      status_type status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic full;
      logic match;
      logic last;
   } flags_type;

endpackage

/* rtl/okvt_ctrl.sv */
module okvt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_mode,
   input  okvt_pkg::flags_type flags,
   output okvt_pkg::cmd_type   cmd,
   output logic                busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   state_type          state_ff, state_in;
   okvt_pkg::mode_type mode_ff, mode_in;
   logic               busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      cmd.status = okvt_pkg::STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               mode_in  = okvt_pkg::mode_type'(req_mode);
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (mode_ff) inside
               okvt_pkg::MODE_INSERT: begin
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
                  if (flags.full) begin
                     cmd.status = okvt_pkg::STATUS_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               okvt_pkg::MODE_CLEAR: begin
                  cmd.clear   = 1'b1;
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
               end
               okvt_pkg::MODE_LOOKUP, okvt_pkg::MODE_REMOVE: begin
                  if (flags.empty) begin
                     cmd.respond = 1'b1;
                     cmd.status  = okvt_pkg::STATUS_NOT_FOUND;
                     state_in    = ST_IDLE;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_SCAN: begin
            if (flags.match) begin
               if (mode_ff == okvt_pkg::MODE_LOOKUP) begin
                  cmd.respond    = 1'b1;
                  cmd.take_value = 1'b1;
                  state_in       = ST_IDLE;
               end else if (flags.last) begin
                  cmd.dec     = 1'b1;
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  // The entry after the match is read next and moved down.
                  cmd.scan_next = 1'b1;
                  state_in      = ST_SHIFT;
               end
            end else if (flags.last) begin
               cmd.respond = 1'b1;
               cmd.status  = okvt_pkg::STATUS_NOT_FOUND;
               state_in    = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (flags.last) begin
               cmd.dec     = 1'b1;
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= okvt_pkg::MODE_INSERT;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

/* rtl/okvt_dp.sv */
module okvt_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [okvt_pkg::DATA_W-1:0]  req_key,
   input  logic signed [okvt_pkg::DATA_W-1:0]  req_value,
   input  okvt_pkg::cmd_type                   cmd,
   output okvt_pkg::flags_type                 flags,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic signed [okvt_pkg::DATA_W-1:0]  rsp_found_value
);

   localparam int IDX_W  = okvt_pkg::IDX_W;
   localparam int CNT_W  = okvt_pkg::CNT_W;
   localparam int DATA_W = okvt_pkg::DATA_W;

   logic [DATA_W-1:0] key_mem [okvt_pkg::TABLE_DEPTH];
   logic [DATA_W-1:0] val_mem [okvt_pkg::TABLE_DEPTH];

   logic [DATA_W-1:0] key_ff, value_ff;
   logic [DATA_W-1:0] key_rd_ff, val_rd_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W:0]    idx_plus;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_key, wr_val;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [DATA_W-1:0] rsp_value_ff;

   assign idx_plus = {1'b0, idx_ff} + {{CNT_W{1'b0}}, 1'b1};

   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.scan_next || cmd.shift) begin
         idx_in = idx_plus[CNT_W-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // A shift writes the entry just read one place lower.
   always_comb begin
      wr_en   = cmd.append || cmd.shift;
      wr_addr = count_ff[IDX_W-1:0];
      wr_key  = key_ff;
      wr_val  = value_ff;
      if (cmd.shift) begin
         wr_addr = idx_ff[IDX_W-1:0] - IDX_W'(1);
         wr_key  = key_rd_ff;
         wr_val  = val_rd_ff;
      end
   end

   // Read data always belongs to the entry that idx_ff points at.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
      key_rd_ff <= key_mem[idx_in[IDX_W-1:0]];
      val_rd_ff <= val_mem[idx_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      idx_ff <= idx_in;
      if (cmd.respond) begin
         rsp_status_ff <= cmd.status;
         rsp_value_ff  <= cmd.take_value ? val_rd_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign flags.empty = (count_ff == '0);
   assign flags.full  = (count_ff == CNT_W'(okvt_pkg::TABLE_DEPTH));
   assign flags.match = (key_rd_ff == key_ff);
   assign flags.last  = (idx_plus == {1'b0, count_ff});

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;

endmodule

/* rtl/ordered_key_value_table.sv */
// Insert and clear are decided in the decode state; lookup and remove compare the
// stored entries in turn in the scan state, and a remove then moves each later
// entry down one place in the shift state. The result beat is registered.
// One item at a time: the next beat is taken at the edge that ends the result
// beat. Results cannot stall.
// Synchronous reset empties the table and drops any pending result.
module ordered_key_value_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_mode,
   input  logic signed [okvt_pkg::DATA_W-1:0]  req_key,
   input  logic signed [okvt_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic signed [okvt_pkg::DATA_W-1:0]  rsp_found_value
);

   okvt_pkg::cmd_type   cmd;
   okvt_pkg::flags_type flags;

   okvt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .flags    (flags),
      .cmd      (cmd),
      .busy     (busy)
   );

   okvt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_key         (req_key),
      .req_value       (req_value),
      .cmd             (cmd),
      .flags           (flags),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value)
   );

endmodule

/* rtl/okvt_chk.sv */
`include "assert_macros.svh"

module okvt_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic [1:0]                          rsp_status,
   input logic signed [okvt_pkg::DATA_W-1:0]  rsp_found_value
);

   logic rsp_not_ok;

   assign rsp_not_ok = rsp_valid && (rsp_status != okvt_pkg::STATUS_OK);

   // An accepted beat keeps the block busy on the next cycle.
   `CHK_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   // A result beat ends the item, so the block is free in that cycle.
   `CHK_ASSERT(a_rsp_free, clock, reset, rsp_valid |-> !busy)
   // Each item gives a single result beat.
   `CHK_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)
   // Only a successful lookup carries a value.
   `CHK_NEVER(a_value_zero, clock, reset, rsp_not_ok && (rsp_found_value != '0))

endmodule

bind ordered_key_value_table okvt_chk u_okvt_chk (.*);
